// ----- hw/rtl/ogr_pkg.sv -----
// Shared types, codes and constants of the occupancy grid ray update block.
package ogr_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ0, ST_READ1, ST_TRIG, ST_MULT, ST_HDIV, ST_HWAIT,
    ST_HFIX, ST_PT, ST_PWAIT, ST_PWR, ST_ADV, ST_FINISH
  } st_t;

  localparam logic OP_INTEGRATE = 1'b0;
  localparam logic OP_READ      = 1'b1;

  localparam logic [2:0] CFG_CELL_SIZE = 3'd0;
  localparam logic [2:0] CFG_COLS      = 3'd1;
  localparam logic [2:0] CFG_ROWS      = 3'd2;
  localparam logic [2:0] CFG_HALF_SIDE = 3'd3;
  localparam logic [2:0] CFG_OCC_CODE  = 3'd4;
  localparam logic [2:0] CFG_FREE_CODE = 3'd5;

  localparam int DIV_NW = 26;
  localparam int DIV_DW = 18;
  localparam int DIV_CW = 5;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] rem0;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
    logic [DIV_CW-1:0] iters;
  } div_req_t;

  localparam int CW = 20;
  localparam logic signed [CW-1:0] ANG_HALF_PI = 20'sd102944;
  localparam logic signed [CW-1:0] ANG_PI      = 20'sd205887;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 20'sd39797;

  function automatic logic [15:0] atan_entry(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd51472;
      4'd1:    v = 16'd30386;
      4'd2:    v = 16'd16055;
      4'd3:    v = 16'd8150;
      4'd4:    v = 16'd4091;
      4'd5:    v = 16'd2047;
      4'd6:    v = 16'd1024;
      4'd7:    v = 16'd512;
      4'd8:    v = 16'd256;
      4'd9:    v = 16'd128;
      4'd10:   v = 16'd64;
      4'd11:   v = 16'd32;
      4'd12:   v = 16'd16;
      4'd13:   v = 16'd8;
      4'd14:   v = 16'd4;
      default: v = 16'd2;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/ogr_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module ogr_div (
  input  logic                     clk,
  input  logic                     rst,
  input  ogr_pkg::div_req_t        req,
  output logic [ogr_pkg::DIV_NW-1:0] quo,
  output logic [ogr_pkg::DIV_DW-1:0] rem,
  output logic                     busy
);
  import ogr_pkg::*;

  logic [DIV_NW-1:0] num;
  logic [DIV_DW-1:0] den;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW:0]   t;

  assign t = {rem, num[DIV_NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.iters;
      rem  <= req.rem0;
      num  <= req.num;
      den  <= req.den;
      quo  <= '0;
    end else if (busy) begin
      if (t >= {1'b0, den}) begin
        rem <= DIV_DW'(t - {1'b0, den});
        quo <= {quo[DIV_NW-2:0], 1'b1};
      end else begin
        rem <= t[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], 1'b0};
      end
      num <= {num[DIV_NW-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ----- hw/rtl/ogr_cordic.sv -----
// Iterative rotation CORDIC giving cosine and sine of a Q2.14 bearing.
module ogr_cordic (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [15:0]          bearing,
  output logic signed [ogr_pkg::CW-1:0] cos_o,
  output logic signed [ogr_pkg::CW-1:0] sin_o,
  output logic                        busy
);
  import ogr_pkg::*;

  logic signed [CW-1:0] x, y, ang, a0, dx, dy, at;
  logic [3:0] i;
  logic neg;

  assign a0 = {{(CW-18){bearing[15]}}, bearing, 2'b00};
  assign dx = x >>> i;
  assign dy = y >>> i;
  assign at = $signed({{(CW-16){1'b0}}, atan_entry(i)});
  assign cos_o = neg ? -x : x;
  assign sin_o = neg ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      i    <= 4'd0;
      x    <= CORDIC_GAIN;
      y    <= '0;
      if (a0 > ANG_HALF_PI) begin
        ang <= a0 - ANG_PI;
        neg <= 1'b1;
      end else if (a0 < -ANG_HALF_PI) begin
        ang <= a0 + ANG_PI;
        neg <= 1'b1;
      end else begin
        ang <= a0;
        neg <= 1'b0;
      end
    end else if (busy) begin
      if (ang >= 0) begin
        x   <= x - dy;
        y   <= y + dx;
        ang <= ang - at;
      end else begin
        x   <= x + dy;
        y   <= y - dx;
        ang <= ang + at;
      end
      i <= i + 4'd1;
      if (i == 4'd15) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ----- hw/rtl/ogr_store.sv -----
// Cell memory with a post-reset pass that fills every cell with the unknown code.
module ogr_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata,
  output logic          clearing
);
  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] ca;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      ca       <= '0;
    end else if (clearing) begin
      ca <= ca + 1'b1;
      if (ca == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[ca] <= 8'hFF;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/occupancy_grid_ray_update.sv -----
// Top level of the occupancy grid ray update block: control sequencer and datapath.
//
// A command beat is taken at a rising edge with start high and busy low. Operation
// read returns one cell. Operation integrate computes the hit point with a
// 16-iteration CORDIC (the range/cell division runs beside it), then two dividers
// split the hit offsets by the step count, and each of the up to MAX_RAY_STEPS+1
// ray points is placed by a pair of cell-index dividers of quotient width QB (7 at
// the default 64x64 grid). The per-point divider loop dominates a full-length ray.
// Every command produces exactly one result beat: done is high for one cycle with
// cell_value, status and cells_written valid in that same cycle. The receiver
// cannot stall, so the result is simply presented once.
// After reset the block clears the cell memory to the unknown code -1, one cell a
// cycle, with busy high. Configuration writes on cfg_we are taken at any time,
// including during that pass; they must only be made while no command is in
// flight.
module occupancy_grid_ray_update #(
  parameter int MAX_COLS      = 64,
  parameter int MAX_ROWS      = 64,
  parameter int MAX_RAY_STEPS = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              operation,
  input  logic [15:0]       range_mm,
  input  logic signed [15:0] bearing,
  input  logic [5:0]        read_col,
  input  logic [5:0]        read_row,
  output logic signed [7:0] cell_value,
  output logic              status,
  output logic [7:0]        cells_written
);
  import ogr_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MAXD  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  // Quotient width of the cell-index dividers: wide enough to exceed any grid size.
  localparam int QB    = $clog2(MAXD) + 1;
  localparam int SW    = $clog2(MAX_RAY_STEPS + 1);
  localparam int HW    = 27;

  // Configuration registers.
  logic [9:0]  cell_size;
  logic [6:0]  grid_cols, grid_rows;
  logic [15:0] half_side;
  logic [7:0]  occ_code, free_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= 10'd50;
      grid_cols <= 7'd60;
      grid_rows <= 7'd48;
      half_side <= 16'd1200;
      occ_code  <= 8'd100;
      free_code <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CELL_SIZE: cell_size <= cfg_data[9:0];
        CFG_COLS:      grid_cols <= cfg_data[6:0];
        CFG_ROWS:      grid_rows <= cfg_data[6:0];
        CFG_HALF_SIDE: half_side <= cfg_data;
        CFG_OCC_CODE:  occ_code  <= cfg_data[7:0];
        CFG_FREE_CODE: free_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Grid limits, clamped to the memory's shape; a zero cell size counts as one.
  logic [11:0] cols_used, rows_used;
  logic [9:0]  cell_eff;
  logic [17:0] cell_q8;
  logic [29:0] lim;

  assign cols_used = (12'(grid_cols) > 12'(MAX_COLS)) ? 12'(MAX_COLS) : 12'(grid_cols);
  assign rows_used = (12'(grid_rows) > 12'(MAX_ROWS)) ? 12'(MAX_ROWS) : 12'(grid_rows);
  assign cell_eff  = (cell_size == 10'd0) ? 10'd1 : cell_size;
  assign cell_q8   = {cell_eff, 8'd0};
  assign lim       = 30'(cell_q8) << QB;

  st_t state, state_next;

  // Latched command.
  logic        op_r;
  logic [15:0] rng;
  logic [5:0]  rcol, rrow;

  // Ray datapath.
  logic [SW-1:0]        steps_n, k, rhx, rhy, rx, ry;
  logic signed [HW-1:0] hx, hy, qhx, qhy, pxa, pya;
  logic                 last;
  logic [7:0]           cnt;
  logic signed [7:0]    val_r;
  logic                 stat_r;

  // Units.
  logic signed [CW-1:0] cs, sn;
  logic                 cordic_busy, cordic_start;
  div_req_t             dreq_x, dreq_y;
  logic [DIV_NW-1:0]    quo_x, quo_y;
  logic [DIV_DW-1:0]    rem_x, rem_y;
  logic                 busy_x, busy_y;

  ogr_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cordic_start), .bearing(bearing),
    .cos_o(cs), .sin_o(sn), .busy(cordic_busy)
  );

  ogr_div u_div_x (
    .clk(clk), .rst(rst), .req(dreq_x), .quo(quo_x), .rem(rem_x), .busy(busy_x)
  );

  ogr_div u_div_y (
    .clk(clk), .rst(rst), .req(dreq_y), .quo(quo_y), .rem(rem_y), .busy(busy_y)
  );

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;
  logic          clearing;

  ogr_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk(clk), .rst(rst), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata), .clearing(clearing)
  );

  // Current ray point in mm Q.8; the row coordinate carries the sideways offset.
  logic signed [HW-1:0] ptx;
  logic signed [HW:0]   pty;
  logic                 skip;
  logic [HW-2:0]        ptx_u;
  logic [HW-1:0]        pty_u;
  logic [QB-1:0]        col_q, row_q;
  logic                 in_grid;
  logic                 accept, rd_out;
  logic [DIV_NW-1:0]    mag_x, mag_y;

  assign ptx   = last ? hx : pxa;
  assign pty   = $signed({(last ? hy[HW-1] : pya[HW-1]), (last ? hy : pya)})
               + $signed({4'd0, half_side, 8'd0});
  assign ptx_u = ptx[HW-2:0];
  assign pty_u = pty[HW-1:0];
  assign skip  = ptx[HW-1] || pty[HW] || (30'(ptx_u) >= lim) || (30'(pty_u) >= lim);
  assign col_q = quo_x[QB-1:0];
  assign row_q = quo_y[QB-1:0];
  assign in_grid = (12'(col_q) < cols_used) && (12'(row_q) < rows_used);
  assign mag_x = hx[HW-1] ? DIV_NW'(-hx) : DIV_NW'(hx);
  assign mag_y = hy[HW-1] ? DIV_NW'(-hy) : DIV_NW'(hy);

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign rd_out = (12'(read_col) >= cols_used) || (12'(read_row) >= rows_used);

  assign raddr = AW'(32'(rrow) * MAX_COLS + 32'(rcol));
  assign waddr = AW'(32'(row_q) * MAX_COLS + 32'(col_q));
  assign wdata = last ? occ_code : free_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, unit requests and memory write.
  always_comb begin
    state_next   = state;
    cordic_start = 1'b0;
    dreq_x       = '0;
    dreq_y       = '0;
    we           = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (!clearing) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_READ) begin
            state_next = rd_out ? ST_FINISH : ST_READ0;
          end else begin
            // Step count division runs alongside the CORDIC.
            cordic_start = 1'b1;
            dreq_x.start = 1'b1;
            dreq_x.num   = {range_mm, 10'd0};
            dreq_x.den   = DIV_DW'(cell_eff);
            dreq_x.iters = DIV_CW'(16);
            state_next   = ST_TRIG;
          end
        end
      end
      ST_READ0: state_next = ST_READ1;
      ST_READ1: state_next = ST_FINISH;
      ST_TRIG: begin
        if (!cordic_busy && !busy_x) state_next = ST_MULT;
      end
      ST_MULT: state_next = ST_HDIV;
      ST_HDIV: begin
        dreq_x.start = 1'b1;
        dreq_x.num   = mag_x;
        dreq_x.den   = DIV_DW'(steps_n);
        dreq_x.iters = DIV_CW'(DIV_NW);
        dreq_y.start = 1'b1;
        dreq_y.num   = mag_y;
        dreq_y.den   = DIV_DW'(steps_n);
        dreq_y.iters = DIV_CW'(DIV_NW);
        state_next   = ST_HWAIT;
      end
      ST_HWAIT: begin
        if (!busy_x && !busy_y) state_next = ST_HFIX;
      end
      ST_HFIX: state_next = ST_PT;
      ST_PT: begin
        if (skip) begin
          state_next = ST_ADV;
        end else begin
          // Points past the range check have quotients below 2^QB.
          dreq_x.start = 1'b1;
          dreq_x.rem0  = DIV_DW'(ptx_u >> QB);
          dreq_x.num   = DIV_NW'(ptx_u[QB-1:0]) << (DIV_NW - QB);
          dreq_x.den   = cell_q8;
          dreq_x.iters = DIV_CW'(QB);
          dreq_y.start = 1'b1;
          dreq_y.rem0  = DIV_DW'(pty_u >> QB);
          dreq_y.num   = DIV_NW'(pty_u[QB-1:0]) << (DIV_NW - QB);
          dreq_y.den   = cell_q8;
          dreq_y.iters = DIV_CW'(QB);
          state_next   = ST_PWAIT;
        end
      end
      ST_PWAIT: begin
        if (!busy_x && !busy_y) state_next = ST_PWR;
      end
      ST_PWR: begin
        we         = in_grid;
        state_next = ST_ADV;
      end
      ST_ADV: state_next = last ? ST_FINISH : ST_PT;
      ST_FINISH: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers.
  logic [15:0]      qlow;
  logic [SW:0]      rx_sum, ry_sum;
  logic [SW-1:0]    rlo_x, rlo_y;
  logic signed [CW+16:0] prod_x, prod_y;

  assign qlow   = quo_x[15:0];
  assign rx_sum = {1'b0, rx} + {1'b0, rhx};
  assign ry_sum = {1'b0, ry} + {1'b0, rhy};
  assign rlo_x  = rem_x[SW-1:0];
  assign rlo_y  = rem_y[SW-1:0];
  assign prod_x = $signed({1'b0, rng}) * cs;
  assign prod_y = $signed({1'b0, rng}) * sn;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_FINISH);
    end
    if (state == ST_FINISH) begin
      cell_value    <= (op_r == OP_READ) ? val_r : 8'sd0;
      status        <= (op_r == OP_READ) ? stat_r : 1'b0;
      cells_written <= (op_r == OP_READ) ? 8'd0 : cnt;
    end
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_r   <= operation;
          rng    <= range_mm;
          rcol   <= read_col;
          rrow   <= read_row;
          cnt    <= 8'd0;
          val_r  <= 8'sd0;
          stat_r <= rd_out;
        end
      end
      ST_READ1: val_r <= rdata;
      ST_TRIG: begin
        if (qlow == 16'd0) begin
          steps_n <= SW'(1);
        end else if (32'(qlow) > MAX_RAY_STEPS) begin
          steps_n <= SW'(MAX_RAY_STEPS);
        end else begin
          steps_n <= SW'(qlow);
        end
      end
      ST_MULT: begin
        hx <= HW'(prod_x >>> 8);
        hy <= HW'(prod_y >>> 8);
      end
      ST_HFIX: begin
        // Floor quotient and non-negative remainder of the signed hit offsets.
        if (!hx[HW-1]) begin
          qhx <= HW'(quo_x);
          rhx <= rlo_x;
        end else if (rlo_x == '0) begin
          qhx <= -HW'(quo_x);
          rhx <= '0;
        end else begin
          qhx <= -HW'(quo_x) - HW'(1);
          rhx <= steps_n - rlo_x;
        end
        if (!hy[HW-1]) begin
          qhy <= HW'(quo_y);
          rhy <= rlo_y;
        end else if (rlo_y == '0) begin
          qhy <= -HW'(quo_y);
          rhy <= '0;
        end else begin
          qhy <= -HW'(quo_y) - HW'(1);
          rhy <= steps_n - rlo_y;
        end
        pxa  <= '0;
        pya  <= '0;
        rx   <= '0;
        ry   <= '0;
        k    <= '0;
        last <= 1'b0;
      end
      ST_PWR: begin
        if (in_grid) cnt <= cnt + 8'd1;
      end
      ST_ADV: begin
        if (!last) begin
          // Point k+1 is floor(hit*(k+1)/steps), carried as quotient and remainder.
          if (rx_sum >= {1'b0, steps_n}) begin
            pxa <= pxa + qhx + HW'(1);
            rx  <= SW'(rx_sum - {1'b0, steps_n});
          end else begin
            pxa <= pxa + qhx;
            rx  <= rx_sum[SW-1:0];
          end
          if (ry_sum >= {1'b0, steps_n}) begin
            pya <= pya + qhy + HW'(1);
            ry  <= SW'(ry_sum - {1'b0, steps_n});
          end else begin
            pya <= pya + qhy;
            ry  <= ry_sum[SW-1:0];
          end
          if (k == steps_n - SW'(1)) begin
            last <= 1'b1;
          end else begin
            k <= k + SW'(1);
          end
        end
      end
      default: ;
    endcase
  end
endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the occupancy grid ray update block.
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the grid and the registers, works out the
// expected result of every accepted command, and checks each result beat.
class ogr_scoreboard;
  typedef struct {
    logic signed [7:0] cell_value;
    logic              status;
    logic [7:0]        cells_written;
  } grid_result_t;

  logic [7:0]   grid [4096];
  int unsigned  cell_mm, cols, rows, half_mm;
  logic [7:0]   occ_code, free_code;
  grid_result_t pending [$];
  int           errors;

  function new();
    foreach (grid[i]) grid[i] = 8'hFF;
    cell_mm = 50;
    cols = 60;
    rows = 48;
    half_mm = 1200;
    occ_code = 8'd100;
    free_code = 8'd0;
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      ogr_pkg::CFG_CELL_SIZE: cell_mm = data[9:0];
      ogr_pkg::CFG_COLS:      cols = data[6:0];
      ogr_pkg::CFG_ROWS:      rows = data[6:0];
      ogr_pkg::CFG_HALF_SIDE: half_mm = data;
      ogr_pkg::CFG_OCC_CODE:  occ_code = data[7:0];
      ogr_pkg::CFG_FREE_CODE: free_code = data[7:0];
      default: ;
    endcase
  endfunction

  // Division rounding toward minus infinity.
  function longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function int unsigned cols_used();
    return (cols > 64) ? 64 : cols;
  endfunction

  function int unsigned rows_used();
    return (rows > 64) ? 64 : rows;
  endfunction

  // Rotation-mode CORDIC on Q.16 angles, with the half-turn fold.
  function void cordic(longint ang, output longint c, output longint s);
    longint x, y, nx, dx, dy;
    bit     flip;
    x = 39797;
    y = 0;
    flip = 0;
    if (ang > 102944) begin
      ang = ang - 205887;
      flip = 1;
    end else if (ang < -102944) begin
      ang = ang + 205887;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (ang >= 0) begin
        nx = x - dy;
        y = y + dx;
        ang = ang - longint'(ogr_pkg::atan_entry(i[3:0]));
      end else begin
        nx = x + dy;
        y = y - dx;
        ang = ang + longint'(ogr_pkg::atan_entry(i[3:0]));
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Writes a code at a Q.8 point; returns 1 when the point falls in the grid.
  function int unsigned paint(longint px, longint py, longint cq8, logic [7:0] code);
    longint col, row;
    col = floor_div(px, cq8);
    row = floor_div(py + longint'(half_mm) * 256, cq8);
    if (col < 0 || col >= cols_used() || row < 0 || row >= rows_used()) return 0;
    grid[row * 64 + col] = code;
    return 1;
  endfunction

  function void note_command(logic op, logic [15:0] range_in, logic signed [15:0] brg,
                             logic [5:0] rcol, logic [5:0] rrow);
    grid_result_t r;
    longint c, s, hx, hy, cq8, steps, rng;
    int unsigned csize, count;
    csize = (cell_mm == 0) ? 1 : cell_mm;
    r.cell_value = 0;
    r.status = 0;
    r.cells_written = 0;
    if (op == ogr_pkg::OP_READ) begin
      if (rcol >= cols_used() || rrow >= rows_used()) r.status = 1;
      else r.cell_value = grid[rrow * 64 + rcol];
    end else begin
      rng = range_in;
      cq8 = longint'(csize) * 256;
      cordic(longint'(brg) * 4, c, s);
      hx = floor_div(rng * c, 256);
      hy = floor_div(rng * s, 256);
      steps = rng / csize;
      if (steps < 1) steps = 1;
      if (steps > 128) steps = 128;
      count = 0;
      for (longint k = 0; k < steps; k++)
        count += paint(floor_div(hx * k, steps), floor_div(hy * k, steps), cq8, free_code);
      count += paint(hx, hy, cq8, occ_code);
      r.cells_written = count[7:0];
    end
    pending.push_back(r);
  endfunction

  function void check_result(logic signed [7:0] cv, logic st, logic [7:0] cw);
    grid_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: result beat with nothing expected: cell_value %0d status %0d cells %0d",
               $time, cv, st, cw);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (cv !== e.cell_value) begin
      $display("%0t: cell_value expected %0d actual %0d", $time, e.cell_value, cv);
      errors++;
    end
    if (st !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, st);
      errors++;
    end
    if (cw !== e.cells_written) begin
      $display("%0t: cells_written expected %0d actual %0d", $time, e.cells_written, cw);
      errors++;
    end
  endfunction
endclass

module testbench;
  import ogr_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int NUM_RANDOM  = 1250;

  logic              clk, rst, start, cfg_we, operation;
  logic [2:0]        cfg_index;
  logic [15:0]       cfg_data, range_mm;
  logic signed [15:0] bearing;
  logic [5:0]        read_col, read_row;
  logic              busy, done, status;
  logic signed [7:0] cell_value;
  logic [7:0]        cells_written;

  ogr_scoreboard grid_model;
  int unsigned   cycle_count = 0;
  bit            steady;  // when set, commands go back to back with no idle gaps

  occupancy_grid_ray_update dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .operation(operation), .range_mm(range_mm), .bearing(bearing),
    .read_col(read_col), .read_row(read_row),
    .cell_value(cell_value), .status(status), .cells_written(cells_written)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Outputs are sampled at the rising edge, before the block's own updates land,
  // so both the command acceptance and the result beat are seen race-free.
  always @(posedge clk) begin
    if (!rst && start && !busy)
      grid_model.note_command(operation, range_mm, bearing, read_col, read_row);
    if (!rst && done)
      grid_model.check_result(cell_value, status, cells_written);
  end

  // A generous watchdog; a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Register write, made at a falling edge and held for one full cycle.
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    grid_model.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_config(logic [15:0] csize, logic [15:0] ncols, logic [15:0] nrows,
                             logic [15:0] half, logic [7:0] occ, logic [7:0] fre);
    write_reg(CFG_CELL_SIZE, csize);
    write_reg(CFG_COLS, ncols);
    write_reg(CFG_ROWS, nrows);
    write_reg(CFG_HALF_SIDE, half);
    write_reg(CFG_OCC_CODE, {8'h00, occ});
    write_reg(CFG_FREE_CODE, {8'h00, fre});
  endtask

  // Issues one command beat. Called at a falling edge; returns at the falling
  // edge after the beat was taken, with start still high so that a following
  // command can go straight out without a gap.
  task automatic issue(logic op, logic [15:0] rng, logic signed [15:0] brg,
                       logic [5:0] rcol, logic [5:0] rrow);
    operation <= op;
    range_mm <= rng;
    bearing <= brg;
    read_col <= rcol;
    read_row <= rrow;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Random idle gap before a beat, about a quarter of the time.
  task automatic maybe_idle();
    if (!steady && $urandom_range(0, 99) < 26) begin
      start <= 1'b0;
      operation <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  // Waits until the last expected beat has come and the block is idle again.
  task automatic drain();
    start <= 1'b0;
    while (grid_model.pending.size() != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic random_command();
    int unsigned csize, pick;
    logic [15:0] rng;
    csize = (grid_model.cell_mm == 0) ? 1 : grid_model.cell_mm;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      issue(OP_READ, 16'($urandom), 16'($urandom), 6'($urandom_range(0, 63)),
            6'($urandom_range(0, 63)));
    end else begin
      // Mostly short rays to keep the run short; some at full range.
      if (pick < 50) rng = 16'($urandom);
      else rng = 16'($urandom_range(0, (csize * 40 > 65535) ? 65535 : csize * 40));
      issue(OP_INTEGRATE, rng, 16'($signed($urandom_range(0, 51472)) - 25736),
            6'($urandom), 6'($urandom));
    end
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      steady = (i >= n / 3 && i < n / 2);
      maybe_idle();
      random_command();
    end
    steady = 0;
    drain();
  endtask

  initial begin
    grid_model = new();
    steady = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_CELL_SIZE;
    cfg_data = '0;
    operation = OP_READ;
    range_mm = '0;
    bearing = '0;
    read_col = '0;
    read_row = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // The block clears its memory after reset with busy high.
    @(negedge clk);
    while (busy) @(negedge clk);

    // Directed beats at the reset configuration: grid corners, edge of the
    // grid in use, empty range, full range, and the extreme bearings.
    issue(OP_READ, 16'd0, 16'sd0, 6'd0, 6'd0);
    issue(OP_READ, 16'd0, 16'sd0, 6'd59, 6'd47);
    issue(OP_READ, 16'd0, 16'sd0, 6'd60, 6'd0);
    issue(OP_READ, 16'd0, 16'sd0, 6'd0, 6'd48);
    issue(OP_READ, 16'hFFFF, -16'sd1, 6'd63, 6'd63);
    issue(OP_INTEGRATE, 16'd0, 16'sd0, 6'd0, 6'd0);
    issue(OP_INTEGRATE, 16'd49, 16'sd0, 6'd0, 6'd0);
    issue(OP_INTEGRATE, 16'd50, 16'sd0, 6'd0, 6'd0);
    issue(OP_INTEGRATE, 16'd1000, 16'sd25736, 6'd0, 6'd0);
    issue(OP_INTEGRATE, 16'd1000, -16'sd25736, 6'd0, 6'd0);
    issue(OP_INTEGRATE, 16'd1150, 16'sd12868, 6'd0, 6'd0);
    issue(OP_INTEGRATE, 16'd65535, 16'sd0, 6'd0, 6'd0);
    issue(OP_INTEGRATE, 16'd2999, -16'sd4000, 6'd0, 6'd0);
    issue(OP_READ, 16'd0, 16'sd0, 6'd0, 6'd24);
    issue(OP_READ, 16'd0, 16'sd0, 6'd20, 6'd24);
    issue(OP_READ, 16'd0, 16'sd0, 6'd1, 6'd24);
    drain();
    random_phase(250);

    // Smallest cells, full grid, no offset, extreme codes.
    load_config(16'd1, 16'd64, 16'd64, 16'd0, 8'h80, 8'h7F);
    issue(OP_INTEGRATE, 16'd40, 16'sd0, 6'd0, 6'd0);
    issue(OP_INTEGRATE, 16'd65535, 16'sd25736, 6'd0, 6'd0);
    issue(OP_READ, 16'd0, 16'sd0, 6'd63, 6'd63);
    drain();
    random_phase(200);

    // Cells of 1000 mm, a one-cell grid, the largest offset.
    load_config(16'd1000, 16'd1, 16'd1, 16'd65535, 8'h7F, 8'h80);
    random_phase(100);

    // Zero cell size behaves as one; oversized grid is clamped.
    load_config(16'd0, 16'd127, 16'd100, 16'd32, 8'h01, 8'hFE);
    random_phase(150);

    // Empty grid: nothing is written and every read reports outside.
    load_config(16'd20, 16'd0, 16'd10, 16'd100, 8'h55, 8'hAA);
    random_phase(60);
    load_config(16'd20, 16'd10, 16'd0, 16'd100, 8'h55, 8'hAA);
    random_phase(60);

    // Random settings for the rest.
    for (int p = 0; p < 4; p++) begin
      load_config(16'($urandom_range(1, 1000)), 16'($urandom_range(1, 64)),
                  16'($urandom_range(1, 64)), 16'($urandom), 8'($urandom), 8'($urandom));
      random_phase(110);
    end

    if (grid_model.errors == 0 && grid_model.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (grid_model.pending.size() != 0)
        $display("%0t: %0d expected results never arrived", $time,
                 grid_model.pending.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
